/* rtl/mlfe_pkg.sv */
// ----------------------------------------------------------------------------
// mlfe_pkg
// Shared types and constants of the multichannel linear fade engine.
// ----------------------------------------------------------------------------
package mlfe_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int LEVEL_BITS_DEF   = 16;

  localparam int ACT_W   = 2;
  localparam int CH_W    = 3;
  localparam int LVL_W   = 16;
  localparam int DUR_W   = 20;
  localparam int STEP_W  = 20;
  localparam int PER_W   = 10;
  localparam int MASK_W  = 8;
  localparam int CFG_W   = 20;
  localparam int CFGI_W  = 2;

  localparam logic [PER_W-1:0] FALLBACK_PERIOD = PER_W'(12);

  typedef enum logic [ACT_W-1:0] {
    ACT_SET  = 2'd0,
    ACT_FADE = 2'd1,
    ACT_TICK = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  localparam logic [CFGI_W-1:0] REG_MAX_LEVEL = 2'd0;
  localparam logic [CFGI_W-1:0] REG_PERIOD    = 2'd1;
  localparam logic [CFGI_W-1:0] REG_DEF_FADE  = 2'd2;
  localparam logic [CFGI_W-1:0] REG_MASK      = 2'd3;

  // Classified command handed from the front to the back.
  typedef struct packed {
    action_t           action;
    logic [CH_W-1:0]   channel;
    logic [LVL_W-1:0]  level;     // already clamped to max_level
    logic [DUR_W-1:0]  duration;  // default applied
    logic              immediate; // fade acts as set immediate
  } cmd_t;

endpackage

/* rtl/multichannel_linear_fade_engine.sv */
// ----------------------------------------------------------------------------
// multichannel_linear_fade_engine
// Per-channel LED brightness fader with linear interpolation.
// ----------------------------------------------------------------------------
//   Channel     Direction  Beat contents
//   s_axis      in         action, channel, level, fade_time
//   m_axis      out        out_channel, out_level; tlast marks the final beat
//   cfg         in         register writes (index, data)
//
// A front stage clamps and classifies each command and places it in a
// two-entry queue; the back end executes it against the channel state.
// A set command is offered as a beat from the S_STEPS state once the output
// register is free. A fade start is bound by the 40-step serial divider that
// works out the step count. A tick on a channel in mid-ramp is again bound
// by that divider, which rounds delta*done/total; a channel on its final
// step skips the divider and an idle channel is passed over. Reset is
// synchronous and clears all fade state at once. A stalled output holds the
// back end while the front keeps queuing.
// ----------------------------------------------------------------------------
module multichannel_linear_fade_engine #(
  parameter int NUM_CHANNELS = mlfe_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] action, [4:2] channel, [20:5] level, [40:21] fade_time
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] out_channel, [18:3] out_level
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [mlfe_pkg::CFGI_W-1:0] cfg_index,
  input  logic [mlfe_pkg::CFG_W-1:0]  cfg_data
);

  logic [mlfe_pkg::LVL_W-1:0]  max_level;
  logic [mlfe_pkg::PER_W-1:0]  tick_period_ms;
  logic [mlfe_pkg::DUR_W-1:0]  default_fade_ms;
  logic [mlfe_pkg::MASK_W-1:0] fade_enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level        <= '1;
      tick_period_ms   <= mlfe_pkg::FALLBACK_PERIOD;
      default_fade_ms  <= '0;
      fade_enable_mask <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfe_pkg::REG_MAX_LEVEL: max_level        <= cfg_data[mlfe_pkg::LVL_W-1:0];
        mlfe_pkg::REG_PERIOD:    tick_period_ms   <= cfg_data[mlfe_pkg::PER_W-1:0];
        mlfe_pkg::REG_DEF_FADE:  default_fade_ms  <= cfg_data;
        mlfe_pkg::REG_MASK:      fade_enable_mask <= cfg_data[mlfe_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  logic           cmd_valid, cmd_ready;
  mlfe_pkg::cmd_t cmd;
  logic [2:0]     o_ch;
  logic [15:0]    o_lvl;

  mlfe_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .action(s_axis_tdata[1:0]), .channel(s_axis_tdata[4:2]),
    .level(s_axis_tdata[20:5]), .fade_time(s_axis_tdata[40:21]),
    .max_level(max_level), .default_fade_ms(default_fade_ms),
    .fade_enable_mask(fade_enable_mask),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  mlfe_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .max_level(max_level), .tick_period_ms(tick_period_ms),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_channel(o_ch), .out_level(o_lvl), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, o_lvl, o_ch};

`ifndef SYNTH
  // A waiting beat keeps its contents until it is taken.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("pending beat changed");
  // A beat that is offered stays offered until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");
`endif

endmodule

/* rtl/mlfe_front.sv */
// ----------------------------------------------------------------------------
// mlfe_front
// Accepts commands, clamps the level, resolves fade fallbacks, and queues
// classified commands for the back end.
// ----------------------------------------------------------------------------
module mlfe_front #(
  parameter int NUM_CHANNELS = mlfe_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mlfe_pkg::ACT_W-1:0]   action,
  input  logic [mlfe_pkg::CH_W-1:0]    channel,
  input  logic [mlfe_pkg::LVL_W-1:0]   level,
  input  logic [mlfe_pkg::DUR_W-1:0]   fade_time,
  input  logic [mlfe_pkg::LVL_W-1:0]   max_level,
  input  logic [mlfe_pkg::DUR_W-1:0]   default_fade_ms,
  input  logic [mlfe_pkg::MASK_W-1:0]  fade_enable_mask,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output mlfe_pkg::cmd_t               cmd
);

  localparam logic [mlfe_pkg::LVL_W-1:0] LMASK =
    mlfe_pkg::LVL_W'((64'd1 << mlfe_pkg::LEVEL_BITS_DEF) - 64'd1);

  // Two-entry queue.
  mlfe_pkg::cmd_t q [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  mlfe_pkg::cmd_t new_cmd;
  logic           push, pop, in_range;
  logic [mlfe_pkg::LVL_W-1:0] lvl_m;

  // The level is cut to the level width before it is clamped.
  assign lvl_m = level & LMASK;

  always_comb begin
    new_cmd.action    = mlfe_pkg::action_t'(action);
    new_cmd.channel   = channel;
    new_cmd.level     = (lvl_m > max_level) ? max_level : lvl_m;
    new_cmd.duration  = (fade_time != '0) ? fade_time : default_fade_ms;
    new_cmd.immediate = !fade_enable_mask[channel] || (new_cmd.duration == '0);
  end

  assign in_range = (32'(channel) < NUM_CHANNELS);
  assign in_ready = (count != 2'd2);
  // Out-of-range set and fade commands are dropped here.
  assign push     = in_valid && in_ready &&
                    (action[1] || in_range);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/mlfe_divider.sv */
// ----------------------------------------------------------------------------
// mlfe_divider
// Radix-2 restoring divider for unsigned operands, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mlfe_divider #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        quot <= num;
        dreg <= den;
      end else if (busy) begin
        if (trial >= {1'b0, dreg}) begin
          rem  <= trial - {1'b0, dreg};
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/mlfe_back.sv */
// ----------------------------------------------------------------------------
// mlfe_back
// Executes classified commands against the per-channel fade state and
// emits changed levels through a one-entry output register.
// ----------------------------------------------------------------------------
module mlfe_back #(
  parameter int NUM_CHANNELS = mlfe_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  mlfe_pkg::cmd_t               cmd,
  input  logic [mlfe_pkg::LVL_W-1:0]   max_level,
  input  logic [mlfe_pkg::PER_W-1:0]   tick_period_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mlfe_pkg::CH_W-1:0]    out_channel,
  output logic [mlfe_pkg::LVL_W-1:0]   out_level,
  output logic                         out_last
);

  localparam int LW   = mlfe_pkg::LVL_W;
  localparam int SW   = mlfe_pkg::STEP_W;
  localparam int CHI  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NUMW = 2 * SW;

  typedef enum logic [2:0] {
    S_IDLE, S_STEPS, S_SCAN, S_DIV, S_EMIT, S_WAIT
  } state_t;

  state_t state;
  mlfe_pkg::cmd_t c;
  logic [LW-1:0]   cur   [NUM_CHANNELS];
  logic [LW-1:0]   tgt   [NUM_CHANNELS];
  logic [LW-1:0]   fstart[NUM_CHANNELS];
  logic [LW:0]     fdelta[NUM_CHANNELS];
  logic [SW-1:0]   total [NUM_CHANNELS];
  logic [SW-1:0]   sdone [NUM_CHANNELS];
  logic [CHI-1:0]  idx;
  logic [CHI-1:0]  ch;
  logic [CHI:0]    nleft;   // fading channels not yet emitted in this tick
  logic            neg;
  logic [LW-1:0]   lvl_c;
  logic [LW-1:0]   res_level; // level of the next tick beat
  logic            busy_q;

  // Divider.
  logic            dv_start, dv_done;
  logic [NUMW-1:0] dv_num, dv_quot;
  logic [SW-1:0]   dv_den;

  mlfe_divider #(.NUM_W(NUMW), .DEN_W(SW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  logic [mlfe_pkg::PER_W-1:0] period;
  logic [SW-1:0]   sd_inc;
  logic [LW:0]     dmag;
  logic [NUMW-1:0] prod;
  logic [LW+1:0]   vsum;

  assign ch     = CHI'(c.channel);
  assign lvl_c  = c.level;
  assign period = (tick_period_ms != '0) ? tick_period_ms : mlfe_pkg::FALLBACK_PERIOD;
  assign sd_inc = (sdone[idx] < total[idx]) ? sdone[idx] + SW'(1) : sdone[idx];
  assign dmag   = fdelta[idx][LW] ? (~fdelta[idx] + (LW+1)'(1)) : fdelta[idx];
  assign prod   = NUMW'(dmag) * NUMW'(sd_inc);

  logic [NUMW-1:0] mag;
  assign mag  = dv_quot;
  assign vsum = neg ? ({2'b0, fstart[idx]} - (LW+2)'(mag))
                    : ({2'b0, fstart[idx]} + (LW+2)'(mag));

  logic fade_active;
  logic [CHI:0] fading_cnt;
  always_comb begin
    fading_cnt = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      fading_cnt = fading_cnt + (CHI+1)'(total[i] != '0);
    end
    fade_active = (fading_cnt != '0);
  end

  assign cmd_ready = (state == S_IDLE);
  assign dv_start  = (state == S_STEPS && !busy_q) ||
                     (state == S_SCAN && total[idx] != '0 && sd_inc < total[idx]);
  assign dv_num    = (state == S_STEPS) ?
                     NUMW'(c.duration) + NUMW'(period) - NUMW'(1) :
                     prod + NUMW'(total[idx] >> 1);
  assign dv_den    = (state == S_STEPS) ? SW'(period) : total[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      busy_q    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cur[i] <= '0; tgt[i] <= '0; fstart[i] <= '0;
        fdelta[i] <= '0; total[i] <= '0; sdone[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          busy_q <= 1'b0;
          if (cmd_valid) begin
            c <= cmd;
            case (cmd.action)
              mlfe_pkg::ACT_SET, mlfe_pkg::ACT_FADE: begin
                state <= S_STEPS;
              end
              mlfe_pkg::ACT_TICK: begin
                idx   <= '0;
                nleft <= fading_cnt;
                state <= fade_active ? S_SCAN : S_IDLE;
              end
              default: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  tgt[i] <= cur[i];
                  fstart[i] <= '0; fdelta[i] <= '0;
                  total[i] <= '0; sdone[i] <= '0;
                end
              end
            endcase
          end
        end
        S_STEPS: begin
          if (c.action == mlfe_pkg::ACT_SET || c.immediate) begin
            // The beat waits until the output register is free.
            if (!out_valid) begin
              cur[ch] <= lvl_c; tgt[ch] <= lvl_c;
              fstart[ch] <= '0; fdelta[ch] <= '0;
              total[ch] <= '0; sdone[ch] <= '0;
              out_channel <= c.channel;
              out_level   <= lvl_c;
              out_last    <= 1'b1;
              out_valid   <= 1'b1;
              state       <= S_WAIT;
            end
          end else if (tgt[ch] == lvl_c) begin
            state <= S_IDLE;
          end else begin
            busy_q <= 1'b1;
            // Only the division started in this state counts.
            if (busy_q && dv_done) begin
              tgt[ch]    <= lvl_c;
              fstart[ch] <= cur[ch];
              fdelta[ch] <= {1'b0, lvl_c} - {1'b0, cur[ch]};
              total[ch]  <= (dv_quot[SW-1:0] == '0) ? SW'(1) : dv_quot[SW-1:0];
              sdone[ch]  <= '0;
              state      <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          if (total[idx] == '0) begin
            idx <= idx + CHI'(1);
          end else begin
            sdone[idx] <= sd_inc;
            neg <= fdelta[idx][LW];
            if (sd_inc >= total[idx]) begin
              cur[idx] <= tgt[idx];
              fstart[idx] <= '0; fdelta[idx] <= '0;
              total[idx] <= '0; sdone[idx] <= '0;
              res_level <= tgt[idx];
              state <= S_EMIT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (dv_done) begin
            if (vsum[LW+1]) begin
              cur[idx] <= '0; res_level <= '0;
            end else if (vsum[LW:0] > {1'b0, max_level}) begin
              cur[idx] <= max_level; res_level <= max_level;
            end else begin
              cur[idx] <= vsum[LW-1:0]; res_level <= vsum[LW-1:0];
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            out_channel <= mlfe_pkg::CH_W'(idx);
            out_level   <= res_level;
            out_last    <= (nleft == (CHI+1)'(1));
            nleft       <= nleft - (CHI+1)'(1);
            if (nleft == (CHI+1)'(1)) begin
              state <= S_WAIT;
            end else begin
              idx   <= idx + CHI'(1);
              state <= S_SCAN;
            end
          end
        end
        S_WAIT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
